### src/hcle_pkg.sv
// Shared types, constants and key table for the content-length header extractor.
`timescale 1ns / 1ps

package hcle_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int LEN_W       = 32;
  localparam int KEY_LEN     = 14;
  localparam int KEY_IDX_W   = 4;
  localparam int PHASE_W     = 3;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       line_end;
  } beat_t;

  typedef struct packed {
    logic             saturated;
    logic             negative;
    logic [LEN_W-1:0] length_value;
    logic             found;
  } result_t;

  function automatic logic key_match(input logic [KEY_IDX_W-1:0] idx, input logic [7:0] b);
    logic [7:0] hi;
    logic       ok;
    begin
      ok = 1'b1;
      case (idx)
        4'd0:    hi = "C";
        4'd1:    hi = "O";
        4'd2:    hi = "N";
        4'd3:    hi = "T";
        4'd4:    hi = "E";
        4'd5:    hi = "N";
        4'd6:    hi = "T";
        4'd7:    hi = "-";
        4'd8:    hi = "L";
        4'd9:    hi = "E";
        4'd10:   hi = "N";
        4'd11:   hi = "G";
        4'd12:   hi = "T";
        4'd13:   hi = "H";
        default: begin
          hi = 8'h00;
          ok = 1'b0;
        end
      endcase
      return ok && ((b == hi) || (b == (hi | CASE_BIT)));
    end
  endfunction

endpackage

### src/hcle_in_stage.sv
// Input register for header beats with advance control.
`timescale 1ns / 1ps

module hcle_in_stage
  import hcle_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  logic  [7:0] s_tdata,  // hdr_byte[7:0]
  input  logic  s_tlast,
  input  logic  out_free,
  output beat_t beat,
  output logic  fire
);

  logic held;

  assign fire     = held && (!beat.line_end || out_free);
  assign s_tready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.hdr_byte <= s_tdata;
      beat.line_end <= s_tlast;
    end
  end

endmodule

### src/hcle_parse_core.sv
// Line parser: key match, whitespace skip and decimal value accumulation.
`timescale 1ns / 1ps

module hcle_parse_core
  import hcle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  beat_t   beat,
  input  logic    fire,
  output result_t res
);

  localparam logic [PHASE_W-1:0] PH_KEY    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_VALUE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FAIL   = 3'd4;

  localparam int PROD_W = VALUE_WIDTH + 4;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  logic [PHASE_W-1:0]     phase, phase_next;
  logic [KEY_IDX_W-1:0]   key_index, key_index_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic sign_minus, sign_minus_next;
  logic digits_done, digits_done_next;
  logic sign_allowed, sign_allowed_next;
  logic overflow_seen, overflow_seen_next;

  logic [7:0]        b;
  logic              is_digit;
  logic              is_ws;
  logic [PROD_W-1:0] acc_ext;
  logic [PROD_W-1:0] prod;
  logic              over;
  logic              value_en;
  logic              value_ctx;
  logic [LEN_W+VALUE_WIDTH-1:0] len_ext;

  assign b        = beat.hdr_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign acc_ext  = {4'b0000, accumulator};
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-4){1'b0}}, b[3:0]};
  assign over     = (prod[PROD_W-1:VALUE_WIDTH] != 4'b0000);

  always_comb begin
    phase_next         = phase;
    key_index_next     = key_index;
    accumulator_next   = accumulator;
    sign_minus_next    = sign_minus;
    digits_done_next   = digits_done;
    sign_allowed_next  = sign_allowed;
    overflow_seen_next = overflow_seen;
    value_en           = 1'b0;
    value_ctx          = 1'b0;

    unique case (phase)
      PH_KEY: begin
        if (key_index >= KEY_IDX_W'(KEY_LEN)) begin
          phase_next = (b == CH_COLON) ? PH_SKIP : PH_FAIL;
        end else if (key_match(key_index, b)) begin
          key_index_next = key_index + 1'b1;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_SKIP: begin
        if ((b != CH_SPACE) && (b != CH_TAB)) begin
          phase_next = PH_VALUE;
          value_en   = 1'b1;
          value_ctx  = 1'b1;
        end
      end
      PH_VALUE: begin
        value_en  = 1'b1;
        value_ctx = 1'b1;
      end
      PH_DIGITS: begin
        value_en = 1'b1;
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase

    if (value_en && !digits_done) begin
      if (is_digit) begin
        accumulator_next  = over ? VALUE_MAX : prod[VALUE_WIDTH-1:0];
        overflow_seen_next = overflow_seen || over;
        sign_allowed_next = 1'b0;
        phase_next        = PH_DIGITS;
      end else if (sign_allowed && value_ctx && is_ws) begin
        digits_done_next = 1'b0;
      end else if (sign_allowed && value_ctx && ((b == CH_PLUS) || (b == CH_MINUS))) begin
        sign_minus_next   = (b == CH_MINUS);
        sign_allowed_next = 1'b0;
      end else begin
        digits_done_next = 1'b1;
      end
    end
  end

  assign len_ext = {{LEN_W{1'b0}}, accumulator_next};

  always_comb begin
    res.found        = (phase_next == PH_VALUE) || (phase_next == PH_DIGITS);
    res.length_value = (phase_next == PH_DIGITS) ? len_ext[LEN_W-1:0] : '0;
    res.negative     = (phase_next == PH_DIGITS) && sign_minus_next;
    res.saturated    = res.found && overflow_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && beat.line_end)) begin
      phase         <= PH_KEY;
      key_index     <= '0;
      accumulator   <= '0;
      sign_minus    <= 1'b0;
      digits_done   <= 1'b0;
      sign_allowed  <= 1'b1;
      overflow_seen <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      key_index     <= key_index_next;
      accumulator   <= accumulator_next;
      sign_minus    <= sign_minus_next;
      digits_done   <= digits_done_next;
      sign_allowed  <= sign_allowed_next;
      overflow_seen <= overflow_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_quiet_when_not_found: assert property (@(posedge clk) disable iff (rst)
    !res.found |-> (res.length_value == '0) && !res.negative && !res.saturated)
    else $error("result fields set on a line that did not match");

  a_negative_needs_found: assert property (@(posedge clk) disable iff (rst)
    res.negative |-> res.found)
    else $error("negative flag without a matched header");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && beat.line_end) |=> (phase == PH_KEY) && (key_index == '0) && !overflow_seen)
    else $error("line state not cleared after last beat");

  a_digits_sign_locked: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DIGITS) |-> !sign_allowed)
    else $error("sign still allowed after digits");
`endif

endmodule

### src/hcle_out_stage.sv
// Result register driving the master-side stream.
`timescale 1ns / 1ps

module hcle_out_stage
  import hcle_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    out_free,
  output logic    m_tvalid,
  input  logic    m_tready,
  output logic    [39:0] m_tdata  // found, length_value[31:0], negative, saturated, zero pad
);

  result_t held_res;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(40 - $bits(result_t)){1'b0}}, held_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_res <= res;
    end
  end

endmodule

### src/http_content_length_extractor_unit.sv
// Latency: a result beat is valid the cycle after the line's last byte leaves the input register.
// Throughput: one header byte per cycle; the input register stalls only on a last byte
//   while the result register still holds an untaken result.
// Reset: synchronous active-high rst empties both registers and returns the parser to key match.
// Top level of the content-length header extractor.
`timescale 1ns / 1ps

module http_content_length_extractor_unit
  import hcle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // hdr_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // found, length_value[31:0], negative, saturated, zero pad
);

  beat_t   beat;
  result_t res;
  logic    fire;
  logic    out_free;

  hcle_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .out_free (out_free),
    .beat     (beat),
    .fire     (fire)
  );

  hcle_parse_core u_core (
    .clk  (clk),
    .rst  (rst),
    .beat (beat),
    .fire (fire),
    .res  (res)
  );

  hcle_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && beat.line_end),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(fire && beat.line_end))
    else $error("result overwritten while waiting");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the content-length header extractor: directed and random header lines.
module tb_top;
  import hcle_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_BEATS = 1300;
  localparam int MAX_SHOWN    = 10;
  localparam longint unsigned VALUE_MAX = (VALUE_WIDTH == 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                          (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam logic [8*KEY_LEN-1:0] KEY_TEXT = "CONTENT-LENGTH";

  typedef enum logic [2:0] {
    LP_KEY,
    LP_SKIP,
    LP_VALUE,
    LP_DIGITS,
    LP_FAIL
  } line_phase_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // hdr_byte[7:0]
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // found, length_value[31:0], negative, saturated, zero pad

  line_phase_t     ph;
  int              key_pos;
  longint unsigned acc;
  bit              minus_seen;
  bit              digits_end;
  bit              sign_ok;
  bit              clamped;

  result_t    length_reports[$];
  result_t    seen_report;
  result_t    want_report;
  logic [7:0] line_buf[$];

  int errors;
  int beats_sent;
  int idle_cycles;
  int stall_left;
  bit src_gaps_on;
  bit sink_stalls_on;

  http_content_length_extractor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  task automatic clear_parser();
    ph         = LP_KEY;
    key_pos    = 0;
    acc        = 0;
    minus_seen = 1'b0;
    digits_end = 1'b0;
    sign_ok    = 1'b1;
    clamped    = 1'b0;
  endtask

  task automatic value_char(input logic [7:0] b);
    longint unsigned d;
    if (digits_end) return;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      d = 64'(b - CH_ZERO);
      if (acc > (VALUE_MAX - d) / 10) begin
        acc     = VALUE_MAX;
        clamped = 1'b1;
      end else begin
        acc = acc * 10 + d;
      end
      sign_ok = 1'b0;
      ph      = LP_DIGITS;
      return;
    end
    if (sign_ok && ph == LP_VALUE) begin
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
      if (b == CH_PLUS || b == CH_MINUS) begin
        minus_seen = (b == CH_MINUS);
        sign_ok    = 1'b0;
        return;
      end
    end
    digits_end = 1'b1;
  endtask

  task automatic parse_header_byte(input logic [7:0] b, input logic last_b);
    logic [7:0] hi;
    logic [7:0] lo;
    result_t    r;
    case (ph)
      LP_KEY: begin
        if (key_pos >= KEY_LEN) begin
          ph = (b == CH_COLON) ? LP_SKIP : LP_FAIL;
        end else begin
          hi = KEY_TEXT[8*(KEY_LEN-1-key_pos) +: 8];
          lo = (hi >= "A" && hi <= "Z") ? (hi | CASE_BIT) : hi;
          if (b == hi || b == lo) key_pos++;
          else ph = LP_FAIL;
        end
      end
      LP_SKIP: begin
        if (b != CH_SPACE && b != CH_TAB) begin
          ph = LP_VALUE;
          value_char(b);
        end
      end
      LP_VALUE, LP_DIGITS: value_char(b);
      default: ph = LP_FAIL;
    endcase
    if (last_b) begin
      r = '0;
      if (ph == LP_VALUE || ph == LP_DIGITS) begin
        r.found        = 1'b1;
        r.length_value = (ph == LP_DIGITS) ? acc[LEN_W-1:0] : '0;
        r.negative     = (ph == LP_DIGITS) && minus_seen;
        r.saturated    = clamped;
      end
      length_reports.push_back(r);
      clear_parser();
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last_b);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last_b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_header_byte(b, last_b);
    beats_sent++;
    gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic send_line_buf();
    for (int i = 0; i < line_buf.size(); i++) send_beat(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line_buf();
  endtask

  task automatic note_failure(input string msg);
    if (errors < MAX_SHOWN) $display("%t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic test_key_matching();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    send_text("CONTENT-LENGTH:4294967295");
    send_text("cOnTeNt-LeNgTh:7");
    send_text("Content-Len:5");
    send_text("Content-LengthX:5");
    send_text("Content-Length");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    send_line_buf();
    send_text("X");
  endtask

  task automatic test_value_parsing();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    send_text("content-length:\t -99999999999");
    send_text("Content-Length: -");
    send_text("Content-Length:--5");
    send_text("Content-Length:abc");
    send_text("Content-Length:0");
    send_text("content-length:4294967296");
    send_text("Content-Length: \t ");
    add_text("Content-Length:");
    line_buf.push_back(8'h0B);
    line_buf.push_back(CH_CR);
    line_buf.push_back(8'h0C);
    line_buf.push_back(8'h0A);
    line_buf.push_back(CH_SPACE);
    add_text("+42x9");
    send_line_buf();
  endtask

  task automatic test_random_lines();
    int         start;
    logic [7:0] c;
    start = beats_sent;
    while (beats_sent < start + RANDOM_BEATS) begin
      if ($urandom_range(0, 15) == 0) begin
        src_gaps_on    = 1'($urandom_range(0, 1));
        sink_stalls_on = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        for (int i = 0; i < KEY_LEN; i++) begin
          c = KEY_TEXT[8*(KEY_LEN-1-i) +: 8];
          if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c | CASE_BIT;
          line_buf.push_back(c);
        end
        case ($urandom_range(0, 19))
          0: line_buf[$urandom_range(0, KEY_LEN - 1)] = 8'($urandom_range(0, 255));
          1: repeat ($urandom_range(1, KEY_LEN - 1)) void'(line_buf.pop_back());
          2: line_buf.push_back(8'($urandom_range(0, 255)));
          default: ;
        endcase
        if ($urandom_range(0, 29) != 0) line_buf.push_back(CH_COLON);
        repeat ($urandom_range(0, 3)) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        if ($urandom_range(0, 7) == 0) line_buf.push_back(8'($urandom_range(9, 13)));
        case ($urandom_range(0, 3))
          0: line_buf.push_back(CH_PLUS);
          1: line_buf.push_back(CH_MINUS);
          default: ;
        endcase
        if ($urandom_range(0, 9) == 0) line_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        case ($urandom_range(0, 5))
          0: repeat ($urandom_range(0, 3)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          1: add_text($sformatf("%0d", $urandom));
          2: begin
            add_text("429496729");
            line_buf.push_back(8'(CH_ZERO + $urandom_range(4, 9)));
          end
          3: repeat ($urandom_range(11, 22)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          default: repeat ($urandom_range(1, 6)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        endcase
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_line_buf();
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_report = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (length_reports.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %h", m_tdata));
      end else begin
        want_report = length_reports.pop_front();
        if (seen_report.found !== want_report.found ||
            seen_report.length_value !== want_report.length_value ||
            seen_report.negative !== want_report.negative ||
            seen_report.saturated !== want_report.saturated) begin
          note_failure($sformatf(
            "expected found=%0d len=%0d neg=%0d sat=%0d, got found=%0d len=%0d neg=%0d sat=%0d",
            want_report.found, want_report.length_value, want_report.negative,
            want_report.saturated, seen_report.found, seen_report.length_value,
            seen_report.negative, seen_report.saturated));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= 8'h00;
    s_tlast        <= 1'b0;
    m_tready       <= 1'b0;
    errors         = 0;
    beats_sent     = 0;
    idle_cycles    = 0;
    stall_left     = 0;
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    clear_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_key_matching();
    test_value_parsing();
    test_random_lines();
    s_tvalid <= 1'b0;
    while (length_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### http_content_length_extractor_unit.f
src/hcle_pkg.sv
src/hcle_in_stage.sv
src/hcle_parse_core.sv
src/hcle_out_stage.sv
src/http_content_length_extractor_unit.sv
sim/tb_top.sv
